// ----- hw/rtl/acpe_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// acpe_pkg
// Shared types and constants for the accumulator-pair execute block.
// ----------------------------------------------------------------------------
package acpe_pkg;

    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 32;
    localparam int REG_COUNT = 16;
    localparam int IDX_W     = $clog2(REG_COUNT);
    localparam int PADDR_W   = 4;
    localparam int ISA_W     = 2;

    localparam logic [ISA_W-1:0]  ISA_EXEC   = ISA_W'(3);
    localparam logic [ISA_W-1:0]  ISA_RESET  = ISA_W'(3);
    localparam logic [ADDR_W-1:0] INT_VECTOR = ADDR_W'(16);
    localparam logic [IDX_W-1:0]  IRET_REG   = IDX_W'(12);

    typedef enum logic [3:0] {
        OP_MVA = 4'd0,
        OP_COA = 4'd1,
        OP_MVB = 4'd2,
        OP_COB = 4'd3,
        OP_CSB = 4'd4,
        OP_SHL = 4'd5,
        OP_SHR = 4'd6,
        OP_AND = 4'd7,
        OP_ORR = 4'd8,
        OP_XOR = 4'd9,
        OP_ADD = 4'd10,
        OP_SUB = 4'd11,
        OP_INT = 4'd12,
        OP_IRE = 4'd13,
        OP_IMV = 4'd14,
        OP_JMP = 4'd15
    } op_t;

    typedef enum logic [1:0] {
        CFG_ISA   = 2'd0,
        CFG_ENTRY = 2'd1,
        CFG_LEN   = 2'd2
    } cfg_idx_t;

    // Outcome of one executed instruction
    typedef struct packed {
        logic [ADDR_W-1:0] ip;
        logic              wr;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic              flag;
        logic              past_end;
    } exec_res_t;

endpackage
`default_nettype wire

// ----- hw/rtl/accumulator_pair_cpu_execute.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// accumulator_pair_cpu_execute
// Execute stage of a small accumulator-pair core: one 8-bit instruction per
// word in, one state report per word out.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                   | payload
//  ----------+-----------+-----------------------------+---------------------
//  instr     | in        | instr_valid / instr_stall   | instruction
//  result    | out       | result_valid / result_stall | next_address .. past_end
//  config    | in        | APB psel/penable/pready     | paddr, pwdata, prdata
//
//  One word per cycle sustained while result is not stalled. The read stage
//  issues the register file read; the execute stage executes and writes back
//  and loads the output register; the register file write port sets the pace.
//  A write-back and a read of the same register on one edge is forwarded.
//  Reset clears the register file (via valid bits), A, B, flag and IP; no
//  clearing pass. A stall on result backs up through the read stage to instr.
// ----------------------------------------------------------------------------
module accumulator_pair_cpu_execute
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // instruction word
    input  wire logic                         instr_valid,
    output logic                              instr_stall,
    input  wire logic [7:0]                   instruction,
    // result word
    output logic                              result_valid,
    input  wire logic                         result_stall,
    output logic      [acpe_pkg::ADDR_W-1:0]  next_address,
    output logic                              reg_written,
    output logic      [acpe_pkg::IDX_W-1:0]   reg_index,
    output logic      [acpe_pkg::DATA_W-1:0]  reg_value,
    output logic      [acpe_pkg::DATA_W-1:0]  a_value,
    output logic      [acpe_pkg::DATA_W-1:0]  b_value,
    output logic                              in_interrupt,
    output logic                              past_end,
    // configuration
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [acpe_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);
    import acpe_pkg::*;

    // configuration registers
    logic [ISA_W-1:0]  isa_reg;
    logic [ADDR_W-1:0] entry_reg;
    logic [ADDR_W-1:0] len_reg;
    logic              cfg_wr;
    cfg_idx_t          cfg_idx;

    // architectural state outside the register file
    logic [DATA_W-1:0] a_reg;
    logic [DATA_W-1:0] b_reg;
    logic [ADDR_W-1:0] ip_reg;
    logic              flag_reg;

    // read stage
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [7:0]        s1_instr_reg;
    logic              accept;
    logic              exec_go;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_data;

    // output word
    logic              out_valid_reg;
    exec_res_t         out_reg;
    exec_res_t         res;

    // ---- configuration port ----
    assign pready  = 1'b1;
    assign cfg_idx = cfg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (cfg_idx)
            CFG_ISA:   prdata = 32'(isa_reg);
            CFG_ENTRY: prdata = 32'(entry_reg);
            CFG_LEN:   prdata = 32'(len_reg);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            isa_reg   <= ISA_RESET;
            entry_reg <= '0;
            len_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                CFG_ISA:   isa_reg   <= pwdata[ISA_W-1:0];
                CFG_ENTRY: entry_reg <= pwdata[ADDR_W-1:0];
                CFG_LEN:   len_reg   <= pwdata[ADDR_W-1:0];
                default:   ;
            endcase
        end
    end

    // ---- handshake ----
    // Execute when the output register is free or being drained this cycle.
    assign exec_go     = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign instr_stall = s1_valid_reg && !exec_go;
    assign accept      = instr_valid && !instr_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (exec_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // interrupt return reads r12, everything else reads r[par]
    assign rd_addr = (op_t'(instruction[7:4]) == OP_IRE) ? IRET_REG
                                                         : instruction[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_instr_reg <= instruction;
        end
    end

    acpe_regfile u_regfile
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (exec_go && res.wr),
        .wr_addr (res.idx),
        .wr_data (res.value)
    );

    acpe_alu u_alu
    (
        .instr    (s1_instr_reg),
        .operand  (rd_data),
        .a        (a_reg),
        .b        (b_reg),
        .ip       (ip_reg),
        .flag     (flag_reg),
        .isa      (isa_reg),
        .prog_len (len_reg),
        .res      (res)
    );

    // ---- architectural state ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= '0;
            b_reg    <= '0;
            ip_reg   <= '0;
            flag_reg <= 1'b0;
        end
        else
        begin
            if (exec_go)
            begin
                a_reg    <= res.a;
                b_reg    <= res.b;
                ip_reg   <= res.ip;
                flag_reg <= res.flag;
            end
            else if (cfg_wr && (cfg_idx == CFG_ENTRY))
            begin
                // entry write acts as a vector load
                ip_reg <= pwdata[ADDR_W-1:0];
            end
        end
    end

    // ---- output register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exec_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_go)
        begin
            out_reg <= res;
        end
    end

    assign result_valid = out_valid_reg;
    assign next_address = out_reg.ip;
    assign reg_written  = out_reg.wr;
    assign reg_index    = out_reg.idx;
    assign reg_value    = out_reg.wr ? out_reg.value : '0;
    assign a_value      = out_reg.a;
    assign b_value      = out_reg.b;
    assign in_interrupt = out_reg.flag;
    assign past_end     = out_reg.past_end;

endmodule
`default_nettype wire

// ----- hw/rtl/acpe_regfile.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// acpe_regfile
// General register memory: one write and one registered read port, valid
// bits for the zero reset, write-to-read forwarding on a same-edge clash.
// ----------------------------------------------------------------------------
module acpe_regfile
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       rd_en,
    input  wire logic [acpe_pkg::IDX_W-1:0] rd_addr,
    output logic      [acpe_pkg::DATA_W-1:0] rd_data,
    input  wire logic                       wr_en,
    input  wire logic [acpe_pkg::IDX_W-1:0] wr_addr,
    input  wire logic [acpe_pkg::DATA_W-1:0] wr_data
);
    import acpe_pkg::*;

    logic [DATA_W-1:0]    mem [REG_COUNT];
    logic [REG_COUNT-1:0] vld_reg;
    logic [DATA_W-1:0]    q_reg;
    logic                 q_vld_reg;
    logic                 fwd_hit_reg;
    logic [DATA_W-1:0]    fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            q_reg        <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            q_vld_reg   <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                q_vld_reg   <= vld_reg[rd_addr];
                // write landing on the same edge: memory returns old data
                fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg :
                     (q_vld_reg  ? q_reg : '0);

endmodule
`default_nettype wire

// ----- hw/rtl/acpe_alu.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// acpe_alu
// Instruction decode and execute: ALU, operand and IP update, end check.
// ----------------------------------------------------------------------------
module acpe_alu
(
    input  wire logic [7:0]                  instr,
    input  wire logic [acpe_pkg::DATA_W-1:0] operand,
    input  wire logic [acpe_pkg::DATA_W-1:0] a,
    input  wire logic [acpe_pkg::DATA_W-1:0] b,
    input  wire logic [acpe_pkg::ADDR_W-1:0] ip,
    input  wire logic                        flag,
    input  wire logic [acpe_pkg::ISA_W-1:0]  isa,
    input  wire logic [acpe_pkg::ADDR_W-1:0] prog_len,
    output acpe_pkg::exec_res_t              res
);
    import acpe_pkg::*;

    op_t               op;
    logic [IDX_W-1:0]  par;
    logic              sh_big;
    logic [DATA_W-1:0] a_n;
    logic [DATA_W-1:0] b_n;
    logic              f_n;
    logic [ADDR_W-1:0] ip_b;
    logic [ADDR_W-1:0] ip_n;
    logic              wr;
    logic [DATA_W-1:0] val;

    assign op     = op_t'(instr[7:4]);
    assign par    = instr[IDX_W-1:0];
    assign sh_big = |b[DATA_W-1:$clog2(DATA_W)];

    always_comb
    begin
        a_n  = a;
        b_n  = b;
        f_n  = flag;
        ip_b = ip;
        wr   = 1'b0;
        val  = '0;
        if (isa == ISA_EXEC)
        begin
            unique case (op)
                OP_MVA: a_n = operand;
                OP_COA: a_n = DATA_W'(par);
                OP_MVB: b_n = operand;
                OP_COB: b_n = DATA_W'(par);
                OP_CSB: b_n = {b[DATA_W-5:0], 4'b0000} + DATA_W'(par);
                OP_SHL:
                begin
                    wr  = 1'b1;
                    val = sh_big ? '0 : (a << b[$clog2(DATA_W)-1:0]);
                end
                OP_SHR:
                begin
                    wr  = 1'b1;
                    val = sh_big ? '0 : (a >> b[$clog2(DATA_W)-1:0]);
                end
                OP_AND:
                begin
                    wr  = 1'b1;
                    val = a & b;
                end
                OP_ORR:
                begin
                    wr  = 1'b1;
                    val = a | b;
                end
                OP_XOR:
                begin
                    wr  = 1'b1;
                    val = a ^ b;
                end
                OP_ADD:
                begin
                    wr  = 1'b1;
                    val = a + b;
                end
                OP_SUB:
                begin
                    wr  = 1'b1;
                    val = a - b;
                end
                OP_INT:
                begin
                    f_n  = 1'b1;
                    ip_b = INT_VECTOR;
                end
                OP_IRE:
                begin
                    // operand was fetched from the return register
                    f_n  = 1'b0;
                    ip_b = ADDR_W'(operand);
                end
                OP_IMV:
                begin
                    wr  = 1'b1;
                    val = DATA_W'(ip);
                end
                OP_JMP:
                begin
                    if (a[0])
                    begin
                        ip_b = ADDR_W'(operand);
                    end
                end
            endcase
        end
    end

    assign ip_n = ip_b + ADDR_W'(1);

    assign res.ip       = ip_n;
    assign res.wr       = wr;
    assign res.idx      = wr ? par : '0;
    assign res.value    = val;
    assign res.a        = a_n;
    assign res.b        = b_n;
    assign res.flag     = f_n;
    assign res.past_end = (ip_n >= prog_len);

endmodule
`default_nettype wire

// ----- test/accumulator_pair_cpu_execute_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_pair_cpu_execute_test
// Self-checking bench: instruction words in, state reports out, compared field
// by field with a behavioural copy of the execute stage kept in this file.
// ----------------------------------------------------------------------------
module accumulator_pair_cpu_execute_test;
    import acpe_pkg::*;

    // Register slot past the end of the map; writes there must be ignored
    localparam logic [1:0] CFG_NONE  = 2'd3;
    localparam int         HOLD_LEN  = 40;
    localparam int         DIR_STEPS = 25;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                instr_valid  = 1'b0;
    logic                instr_stall;
    logic [7:0]          instruction  = 8'h00;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [ADDR_W-1:0]   next_address;
    logic                reg_written;
    logic [IDX_W-1:0]    reg_index;
    logic [DATA_W-1:0]   reg_value;
    logic [DATA_W-1:0]   a_value;
    logic [DATA_W-1:0]   b_value;
    logic                in_interrupt;
    logic                past_end;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [PADDR_W-1:0]  paddr        = '0;
    logic [31:0]         pwdata       = '0;
    logic [31:0]         prdata;
    logic                pready;

    accumulator_pair_cpu_execute dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .instr_valid  (instr_valid),
        .instr_stall  (instr_stall),
        .instruction  (instruction),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .next_address (next_address),
        .reg_written  (reg_written),
        .reg_index    (reg_index),
        .reg_value    (reg_value),
        .a_value      (a_value),
        .b_value      (b_value),
        .in_interrupt (in_interrupt),
        .past_end     (past_end),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // ------------------------------------------------------------------------
    // Shadow machine: register file, A/B, IP, flag and the three settings.
    // ------------------------------------------------------------------------
    logic [DATA_W-1:0] gpr [REG_COUNT];
    logic [ADDR_W-1:0] ip;
    logic [DATA_W-1:0] opa;
    logic [DATA_W-1:0] opb;
    logic              iflag;
    logic [ISA_W-1:0]  cfg_isa;
    logic [ADDR_W-1:0] cfg_entry;
    logic [ADDR_W-1:0] cfg_len;

    exec_res_t state_reports [$];   // reports still owed by the block
    int        mismatches = 0;

    // Idle settings shared with the result-side process
    int        send_idle  = 0;
    int        stall_pct  = 0;
    bit        hold_req   = 1'b0;
    bit        hold_done  = 1'b0;
    int        hold_left  = 0;

    // Executes one word on the shadow machine and returns the report it owes.
    function automatic exec_res_t run_instruction(input logic [7:0] w);
        op_t               op;
        logic [IDX_W-1:0]  par;
        logic              wr;
        logic [DATA_W-1:0] res;
        exec_res_t         r;
        op  = op_t'(w[7:4]);
        par = w[3:0];
        wr  = 1'b0;
        res = '0;
        if (cfg_isa == ISA_EXEC)
        begin
            case (op)
                OP_MVA: opa = gpr[par];
                OP_COA: opa = DATA_W'(par);
                OP_MVB: opb = gpr[par];
                OP_COB: opb = DATA_W'(par);
                OP_CSB: opb = (opb << 4) + DATA_W'(par);
                // shift distances of a full word or more clear the result
                OP_SHL:
                begin
                    res = (opb >= DATA_W) ? '0 : (opa << opb);
                    wr  = 1'b1;
                end
                OP_SHR:
                begin
                    res = (opb >= DATA_W) ? '0 : (opa >> opb);
                    wr  = 1'b1;
                end
                OP_AND: begin res = opa & opb; wr = 1'b1; end
                OP_ORR: begin res = opa | opb; wr = 1'b1; end
                OP_XOR: begin res = opa ^ opb; wr = 1'b1; end
                OP_ADD: begin res = opa + opb; wr = 1'b1; end
                OP_SUB: begin res = opa - opb; wr = 1'b1; end
                OP_INT:
                begin
                    iflag = 1'b1;
                    ip    = INT_VECTOR;
                end
                OP_IRE:
                begin
                    iflag = 1'b0;
                    ip    = ADDR_W'(gpr[IRET_REG]);
                end
                // Imv stores the address of the Imv word itself
                OP_IMV: begin res = DATA_W'(ip); wr = 1'b1; end
                OP_JMP: if (opa[0]) ip = ADDR_W'(gpr[par]);
                default: ;
            endcase
            if (wr)
                gpr[par] = res;
        end
        // IP always steps, jumps and interrupts included
        ip         = ip + 1'b1;
        r.ip       = ip;
        r.wr       = wr;
        r.idx      = wr ? par : '0;
        r.value    = wr ? res : '0;
        r.a        = opa;
        r.b        = opb;
        r.flag     = iflag;
        r.past_end = (ip >= cfg_len);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Directed words. Early rows carry their report typed in; the rest lean
    // on the shadow machine. Covers both encoding extremes, every opcode, the
    // large-shift clear at and above a full word, wrap on subtract, the
    // interrupt round trip and a jump taken and not taken.
    // ------------------------------------------------------------------------
    typedef struct {
        logic [7:0] word;
        bit         known;
        exec_res_t  want;
    } dir_step_t;

    dir_step_t dir_table [DIR_STEPS] = '{
        '{{OP_COA, 4'd15}, 1'b1, '{32'd1, 1'b0, 4'd0, 32'd0, 32'd15, 32'd0, 1'b0, 1'b1}},
        '{{OP_COB, 4'd15}, 1'b1, '{32'd2, 1'b0, 4'd0, 32'd0, 32'd15, 32'd15, 1'b0, 1'b1}},
        '{{OP_CSB, 4'd15}, 1'b1, '{32'd3, 1'b0, 4'd0, 32'd0, 32'd15, 32'd255, 1'b0, 1'b1}},
        '{{OP_ADD, 4'd0},  1'b1, '{32'd4, 1'b1, 4'd0, 32'd270, 32'd15, 32'd255, 1'b0, 1'b1}},
        '{{OP_SUB, 4'd1},  1'b1,
          '{32'd5, 1'b1, 4'd1, 32'hFFFF_FF10, 32'd15, 32'd255, 1'b0, 1'b1}},
        '{{OP_SHL, 4'd2},  1'b1, '{32'd6, 1'b1, 4'd2, 32'd0, 32'd15, 32'd255, 1'b0, 1'b1}},
        '{{OP_SHR, 4'd3},  1'b1, '{32'd7, 1'b1, 4'd3, 32'd0, 32'd15, 32'd255, 1'b0, 1'b1}},
        '{{OP_AND, 4'd4},  1'b0, '0},
        '{{OP_ORR, 4'd5},  1'b0, '0},
        '{{OP_XOR, 4'd6},  1'b0, '0},
        '{{OP_MVA, 4'd1},  1'b0, '0},
        '{{OP_COB, 4'd1},  1'b0, '0},
        '{{OP_CSB, 4'd15}, 1'b0, '0},   // B = 31, widest real shift
        '{{OP_SHR, 4'd8},  1'b0, '0},
        '{{OP_COB, 4'd2},  1'b0, '0},
        '{{OP_CSB, 4'd0},  1'b0, '0},   // B = 32, first clearing distance
        '{{OP_SHL, 4'd9},  1'b0, '0},
        '{{OP_MVB, 4'd0},  1'b0, '0},
        '{{OP_IMV, 4'd12}, 1'b0, '0},   // return address for ire
        '{{OP_INT, 4'd0},  1'b0, '0},
        '{{OP_IRE, 4'd0},  1'b0, '0},
        '{{OP_COA, 4'd1},  1'b0, '0},
        '{{OP_JMP, 4'd12}, 1'b0, '0},   // A odd: taken
        '{{OP_MVA, 4'd0},  1'b0, '0},
        '{{OP_JMP, 4'd15}, 1'b0, '0}    // A even: falls through
    };

    // ------------------------------------------------------------------------
    // Instruction side. Valid is only lowered while idling, so a word that
    // follows straight on keeps valid high across the edge.
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [7:0] w);
        while ($urandom_range(99) < send_idle)
        begin
            instr_valid <= 1'b0;
            @(posedge clk);
        end
        instr_valid <= 1'b1;
        instruction <= w;
        do
            @(posedge clk);
        while (instr_stall);
    endtask

    // APB write, then a read-back on the same selection; the slot past the
    // map is written only. The transfer closes with psel and penable dropped.
    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] v);
        logic [31:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            CFG_ISA:   cfg_isa = v[ISA_W-1:0];
            CFG_ENTRY:
            begin
                cfg_entry = v;
                ip        = v;   // entry write reloads IP straight away
            end
            CFG_LEN:   cfg_len = v;
            default: ;
        endcase
        if (idx != CFG_NONE)
        begin
            want = (idx == CFG_ISA)   ? 32'(cfg_isa) :
                   (idx == CFG_ENTRY) ? cfg_entry : cfg_len;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            if (prdata !== want)
            begin
                $display("%0t: register %0d read back exp %h got %h",
                         $time, idx, want, prdata);
                mismatches++;
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Random words; with squeeze set, halfway through the receiver is held
    // off long enough for the block to fill and push back.
    task automatic run_phase(input int words, input int s_idle, input int r_stall,
                             input bit squeeze);
        logic [7:0] w;
        send_idle = s_idle;
        stall_pct = r_stall;
        for (int n = 0; n < words; n++)
        begin
            if (squeeze && n == words / 2)
                hold_req = 1'b1;
            w = 8'($urandom_range(0, 255));
            send_word(w);
            state_reports.push_back(run_instruction(w));
        end
        // drain before anything touches the settings
        instr_valid <= 1'b0;
        while (state_reports.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, plus one long hold counted here.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            result_stall <= 1'b1;
            hold_left    <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            result_stall <= 1'b1;
            hold_left    <= HOLD_LEN;
            hold_done    <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s exp %h got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        exec_res_t e;
        if (rst_n && result_valid && !result_stall)
        begin
            if (state_reports.size() == 0)
            begin
                $display("%0t: result word with nothing expected", $time);
                mismatches++;
            end
            else
            begin
                e = state_reports.pop_front();
                check_field("next_address", e.ip, next_address);
                check_field("reg_written", 32'(e.wr), 32'(reg_written));
                check_field("reg_index", 32'(e.idx), 32'(reg_index));
                check_field("reg_value", e.value, reg_value);
                check_field("a_value", e.a, a_value);
                check_field("b_value", e.b, b_value);
                check_field("in_interrupt", 32'(e.flag), 32'(in_interrupt));
                check_field("past_end", 32'(e.past_end), 32'(past_end));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        exec_res_t r;
        for (int k = 0; k < REG_COUNT; k++)
            gpr[k] = '0;
        ip        = '0;
        opa       = '0;
        opb       = '0;
        iflag     = 1'b0;
        cfg_isa   = ISA_RESET;
        cfg_entry = '0;
        cfg_len   = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words on reset settings, full rate both sides
        foreach (dir_table[i])
        begin
            send_word(dir_table[i].word);
            r = run_instruction(dir_table[i].word);
            state_reports.push_back(dir_table[i].known ? dir_table[i].want : r);
        end
        instr_valid <= 1'b0;
        while (state_reports.size() != 0)
            @(posedge clk);

        // no idling either side
        cfg_write(CFG_LEN, $urandom);
        run_phase(160, 0, 0, 1'b0);

        // IP starts at the top of the address space and wraps; length at max
        cfg_write(CFG_ENTRY, 32'hFFFF_FFFF);
        cfg_write(CFG_LEN, 32'hFFFF_FFFF);
        run_phase(160, 48, 0, 1'b0);

        // non-executing versions: IP steps only; junk in the upper data bits
        for (int v = 0; v < 3; v++)
        begin
            cfg_write(CFG_ISA, ($urandom & ~32'h3) | 32'(v));
            cfg_write(CFG_ENTRY, $urandom);
            run_phase(20, 0, 48, 1'b0);
        end

        // write past the map must change nothing
        cfg_write(CFG_NONE, $urandom);
        cfg_write(CFG_ISA, ($urandom & ~32'h3) | 32'(ISA_EXEC));
        cfg_write(CFG_ENTRY, $urandom);
        cfg_write(CFG_LEN, 32'h0);
        run_phase(150, 30, 30, 1'b0);

        // small program near zero, long receiver hold mid-phase
        cfg_write(CFG_ENTRY, 32'h0);
        cfg_write(CFG_LEN, 32'($urandom_range(1, 64)));
        run_phase(150, 0, 0, 1'b1);

        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("** accumulator_pair_cpu_execute: PASSED **");
        else
            $display("** accumulator_pair_cpu_execute: FAILED **");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("** accumulator_pair_cpu_execute: FAILED **");
        $finish;
    end

endmodule
